// ===== rtl/hfp_pkg.sv =====
// shared types and constants of the hevc rtp fragmentation packetizer
package hfp_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_BITS  = 3;
  localparam logic REG_MAX_PACKET_SIZE = 1'b0;
  localparam logic REG_TIMESTAMP_STEP  = 1'b1;

  localparam logic [15:0] MAX_PACKET_RESET = 16'd1400;
  localparam logic [31:0] TS_STEP_RESET    = 32'd3000;
  localparam logic [15:0] MIN_PACKET       = 16'd4;
  localparam logic [15:0] FU_OVERHEAD      = 16'd3;

  localparam logic [7:0] FU_INDICATOR = 8'd98;
  localparam logic [7:0] FU_LAYER_TID = 8'd1;
  localparam logic [7:0] S_BIT        = 8'h80;
  localparam logic [7:0] E_BIT        = 8'h40;
  localparam logic [5:0] TYPE_VPS     = 6'd32;
  localparam logic [5:0] TYPE_PPS     = 6'd34;

  // one queued packetizer command: a data byte, optionally led by the fu indicator, layer byte and fu header
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  fu_hdr;
    logic        with_hdr;
    logic        pfirst;
    logic        plast;
    logic [15:0] seq;
    logic [31:0] stamp;
  } hfp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hfp_qstat_t;

  typedef enum logic [1:0] {
    STEP_IND,
    STEP_TID,
    STEP_FU,
    STEP_DATA
  } hfp_step_t;

endpackage

// ===== rtl/hfp_channels.sv =====
// request channel interfaces for nal bytes in and rtp payload bytes out
interface hfp_in_if;
  import hfp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [7:0]             nal_byte;
  logic [LENGTH_BITS-1:0] nal_length;
  logic                   first_of_nal;

  modport source (output valid, nal_byte, nal_length, first_of_nal, input ready);
  modport sink (input valid, nal_byte, nal_length, first_of_nal, output ready);
endinterface

interface hfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        packet_first;
  logic        packet_last;
  logic [15:0] seq_number;
  logic [31:0] timestamp;
  logic        run_last;

  modport source (output valid, payload_byte, packet_first, packet_last, seq_number,
                  timestamp, run_last, input ready);
  modport sink (input valid, payload_byte, packet_first, packet_last, seq_number,
                timestamp, run_last, output ready);
endinterface

// ===== rtl/hfp_front.sv =====
// front end: accepts nal bytes, tracks unit and packet state, issues commands
module hfp_front (
  input  logic                clk,
  input  logic                rst,
  hfp_in_if.sink              in_ch,
  input  logic [15:0]         max_packet_size,
  input  logic [31:0]         timestamp_step,
  input  hfp_pkg::hfp_qstat_t q_stat,
  output logic                push,
  output hfp_pkg::hfp_cmd_t   cmd
);
  import hfp_pkg::*;

  logic                   fragment_mode, fragment_mode_next;
  logic [5:0]             unit_type, unit_type_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [15:0]            fill_in_packet, fill_in_packet_next;
  logic [15:0]            seq_count, seq_count_next;
  logic [31:0]            rtp_time, rtp_time_next;
  logic                   skip_left, skip_left_next;
  logic                   start_pending, start_pending_next;
  logic [15:0]            latched_size, latched_size_next;

  logic                   accept;
  logic                   active;
  logic                   cmd_valid;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] bl_dec;
  logic [15:0]            payload;
  logic [15:0]            fill_inc;
  logic                   plast;
  logic [7:0]             fu;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && cmd_valid;
  assign len         = in_ch.nal_length;

  always_comb begin
    fragment_mode_next  = fragment_mode;
    unit_type_next      = unit_type;
    bytes_left_next     = bytes_left;
    fill_in_packet_next = fill_in_packet;
    seq_count_next      = seq_count;
    rtp_time_next       = rtp_time;
    skip_left_next      = skip_left;
    start_pending_next  = start_pending;
    latched_size_next   = latched_size;
    active              = 1'b0;
    cmd_valid           = 1'b0;
    cmd                 = '0;
    bl_dec              = '0;
    payload             = '0;
    fill_inc            = '0;
    plast               = 1'b0;
    fu                  = '0;

    if (in_ch.first_of_nal) begin
      // a new unit abandons an open one; a begun packet still uses its number
      if (bytes_left != '0 && fill_in_packet != '0) begin
        seq_count_next = seq_count + 16'd1;
      end
      bytes_left_next     = '0;
      fill_in_packet_next = '0;
      skip_left_next      = 1'b0;
      start_pending_next  = 1'b0;
      if (len != '0) begin
        unit_type_next    = in_ch.nal_byte[6:1];
        latched_size_next = (max_packet_size < MIN_PACKET) ? MIN_PACKET : max_packet_size;
        if (len <= LENGTH_BITS'(latched_size_next)) begin
          fragment_mode_next = 1'b0;
          bytes_left_next    = len;
          active             = 1'b1;
        end else begin
          // first header byte dropped here, second one on the next item
          fragment_mode_next = 1'b1;
          bytes_left_next    = len - LENGTH_BITS'(1);
          skip_left_next     = 1'b1;
          start_pending_next = 1'b1;
        end
      end
    end else begin
      active = (bytes_left != '0);
    end

    if (active) begin
      bl_dec       = bytes_left_next - LENGTH_BITS'(1);
      fill_inc     = fill_in_packet_next + 16'd1;
      cmd.data     = in_ch.nal_byte;
      cmd.seq      = seq_count_next;
      cmd.stamp    = rtp_time;
      if (!fragment_mode_next) begin
        plast               = (bytes_left_next == LENGTH_BITS'(1));
        cmd_valid           = 1'b1;
        cmd.pfirst          = (fill_in_packet_next == '0);
        cmd.plast           = plast;
        fill_in_packet_next = fill_inc;
        bytes_left_next     = bl_dec;
        if (plast) begin
          seq_count_next      = seq_count_next + 16'd1;
          fill_in_packet_next = '0;
          if (unit_type_next < TYPE_VPS || unit_type_next > TYPE_PPS) begin
            rtp_time_next = rtp_time + timestamp_step;
          end
        end
      end else if (skip_left_next) begin
        skip_left_next  = 1'b0;
        bytes_left_next = bl_dec;
      end else begin
        payload = latched_size_next - FU_OVERHEAD;
        fu      = {2'b00, unit_type_next};
        if (start_pending_next) begin
          fu = fu | S_BIT;
        end
        if (bytes_left_next <= LENGTH_BITS'(payload)) begin
          fu = fu | E_BIT;
        end
        cmd_valid    = 1'b1;
        cmd.with_hdr = (fill_in_packet_next == '0);
        cmd.fu_hdr   = fu;
        if (fill_in_packet_next == '0) begin
          start_pending_next = 1'b0;
        end
        plast               = (fill_inc >= payload) || (bl_dec == '0);
        cmd.plast           = plast;
        fill_in_packet_next = fill_inc;
        bytes_left_next     = bl_dec;
        if (plast) begin
          seq_count_next      = seq_count_next + 16'd1;
          fill_in_packet_next = '0;
        end
        if (bl_dec == '0) begin
          rtp_time_next = rtp_time + timestamp_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_mode  <= 1'b0;
      unit_type      <= '0;
      bytes_left     <= '0;
      fill_in_packet <= '0;
      seq_count      <= '0;
      rtp_time       <= '0;
      skip_left      <= 1'b0;
      start_pending  <= 1'b0;
      latched_size   <= MIN_PACKET;
    end else if (accept) begin
      fragment_mode  <= fragment_mode_next;
      unit_type      <= unit_type_next;
      bytes_left     <= bytes_left_next;
      fill_in_packet <= fill_in_packet_next;
      seq_count      <= seq_count_next;
      rtp_time       <= rtp_time_next;
      skip_left      <= skip_left_next;
      start_pending  <= start_pending_next;
      latched_size   <= latched_size_next;
    end
  end

endmodule

// ===== rtl/hfp_queue.sv =====
// short command queue between front end and byte emitter
module hfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hfp_pkg::hfp_cmd_t   push_cmd,
  input  logic                pop,
  output hfp_pkg::hfp_cmd_t   head,
  output hfp_pkg::hfp_qstat_t q_stat
);
  import hfp_pkg::*;

  hfp_cmd_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign q_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/hfp_back.sv =====
// back end: expands commands into payload bytes through the output register
module hfp_back (
  input  logic                clk,
  input  logic                rst,
  input  hfp_pkg::hfp_cmd_t   head,
  input  hfp_pkg::hfp_qstat_t q_stat,
  output logic                pop,
  hfp_out_if.source           out_ch
);
  import hfp_pkg::*;

  hfp_step_t   step, step_next;
  logic        load;
  logic        take;
  logic [7:0]  el_byte;
  logic        el_first;
  logic        el_last;
  logic        el_run_last;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_first;
  logic        out_last;
  logic [15:0] out_seq;
  logic [31:0] out_stamp;
  logic        out_run_last;

  assign load = !out_valid || out_ch.ready;
  assign take = load && !q_stat.empty;

  always_comb begin
    step_next   = step;
    pop         = 1'b0;
    el_byte     = head.data;
    el_first    = 1'b0;
    el_last     = head.plast;
    el_run_last = 1'b1;
    if (!head.with_hdr) begin
      el_first = head.pfirst;
      pop      = take;
    end else begin
      case (step)
        STEP_IND: begin
          el_byte     = FU_INDICATOR;
          el_first    = 1'b1;
          el_last     = 1'b0;
          el_run_last = 1'b0;
          if (take) step_next = STEP_TID;
        end
        STEP_TID: begin
          el_byte     = FU_LAYER_TID;
          el_last     = 1'b0;
          el_run_last = 1'b0;
          if (take) step_next = STEP_FU;
        end
        STEP_FU: begin
          el_byte     = head.fu_hdr;
          el_last     = 1'b0;
          el_run_last = 1'b0;
          if (take) step_next = STEP_DATA;
        end
        STEP_DATA: begin
          pop = take;
          if (take) step_next = STEP_IND;
        end
        default: begin
          step_next = STEP_IND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IND;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte     <= el_byte;
      out_first    <= el_first;
      out_last     <= el_last;
      out_seq      <= head.seq;
      out_stamp    <= head.stamp;
      out_run_last <= el_run_last;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.payload_byte = out_byte;
  assign out_ch.packet_first = out_first;
  assign out_ch.packet_last  = out_last;
  assign out_ch.seq_number   = out_seq;
  assign out_ch.timestamp    = out_stamp;
  assign out_ch.run_last     = out_run_last;

endmodule

// ===== rtl/hevc_rtp_fu_packetizer.sv =====
// top level of the hevc rtp fragmentation-unit packetizer with its apb registers
// a nal byte's results pass through the command queue and the output register
// throughput: one nal byte per cycle while the queue has room; a byte that
//   opens an fu packet gives four results, which a four-entry queue absorbs
// single output register sets the rate: one payload byte a cycle unless stalled
// reset: synchronous, clears unit and packet state, counters, queue and output
module hevc_rtp_fu_packetizer (
  input  logic                           clk,
  input  logic                           rst,
  hfp_in_if.sink                         in_ch,
  hfp_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hfp_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import hfp_pkg::*;

  // configuration registers
  logic [15:0] max_packet_size;
  logic [31:0] timestamp_step;
  logic        cfg_write;
  logic        reg_sel;

  // front to queue to back
  logic       push;
  hfp_cmd_t   push_cmd;
  logic       pop;
  hfp_cmd_t   head;
  hfp_qstat_t q_stat;

  // apb: no wait states, register picked by the word address bit
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_size <= MAX_PACKET_RESET;
      timestamp_step  <= TS_STEP_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MAX_PACKET_SIZE: max_packet_size <= pwdata[15:0];
        REG_TIMESTAMP_STEP:  timestamp_step  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_PACKET_SIZE: prdata = {16'd0, max_packet_size};
      REG_TIMESTAMP_STEP:  prdata = timestamp_step;
      default:             prdata = '0;
    endcase
  end

  // front end: classifies each byte and keeps sequence number and timestamp
  hfp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .max_packet_size (max_packet_size),
    .timestamp_step  (timestamp_step),
    .q_stat          (q_stat),
    .push            (push),
    .cmd             (push_cmd)
  );

  // decoupling queue, so header insertion stalls the front end only once it is full
  hfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back end: one payload byte per cycle into the output register unless the output stalls
  hfp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // fu indicator, layer byte and fu header never close a packet
  a_hdr_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.run_last) |-> !out_ch.packet_last)
    else $error("header byte marked as packet end");

  // nothing queued and nothing shown means nothing shown next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (q_stat.empty && !out_ch.valid) |=> !out_ch.valid)
    else $error("result appeared without a queued command");

  // output register empty after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the hevc rtp fu packetizer: directed units, random units, apb setup
module testbench;
  import hfp_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  // longest quiet spell of a correct run is one long gap or stall
  localparam int WATCHDOG_LIMIT = 2000;
  // output follows its nal byte through the queue and output register; leave a margin before touching registers
  localparam int SETTLE_CYCLES  = 10;
  localparam int RANDOM_ITEMS   = 160;
  localparam int PHASES         = 4;

  localparam logic [PADDR_BITS-1:0] ADDR_MAX_PACKET = {REG_MAX_PACKET_SIZE, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_TS_STEP    = {REG_TIMESTAMP_STEP, 2'b00};

  // nal header first bytes of the parameter-set types
  localparam logic [7:0] HDR_VPS = {1'b0, TYPE_VPS, 1'b0};
  localparam logic [7:0] HDR_PPS = {1'b0, TYPE_PPS, 1'b0};

  // one payload byte as the block should present it
  typedef struct packed {
    logic [7:0]  data;
    logic        pfirst;
    logic        plast;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic        run_last;
  } rtp_byte_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hfp_in_if  in_ch ();
  hfp_out_if out_ch ();

  hevc_rtp_fu_packetizer dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // packetizer shadow: registers as last written, unit and packet progress
  logic [15:0]            cfg_max_pkt;
  logic [31:0]            cfg_ts_step;
  logic                   frag_mode;
  logic [5:0]             cur_type;
  logic [LENGTH_BITS-1:0] remain;
  logic [15:0]            pkt_fill;
  logic [15:0]            seq_ctr;
  logic [31:0]            rtp_clock;
  logic                   drop_hdr;
  logic                   s_pending;
  logic [15:0]            unit_limit;

  rtp_byte_t   payload_exp[$];
  int unsigned errors;
  int unsigned reg_errors;
  int unsigned idle_cycles;

  // stimulus controls
  logic        tx_idle;
  logic        rx_stalls;
  logic        rx_ready = 1'b0;
  int unsigned stall_left;
  int unsigned phase_limit;
  logic        open_unit;

  assign out_ch.ready = rx_ready;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // gap length: mostly none, often a few cycles, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void shadow_reset();
    cfg_max_pkt = MAX_PACKET_RESET;
    cfg_ts_step = TS_STEP_RESET;
    frag_mode   = 1'b0;
    cur_type    = '0;
    remain      = '0;
    pkt_fill    = '0;
    seq_ctr     = '0;
    rtp_clock   = '0;
    drop_hdr    = 1'b0;
    s_pending   = 1'b0;
    unit_limit  = MIN_PACKET;
  endfunction

  // every byte of a packet carries that packet's number and timestamp
  function automatic rtp_byte_t payload_of(input logic [7:0] data, input logic pfirst,
                                           input logic plast);
    rtp_byte_t r;
    r.data     = data;
    r.pfirst   = pfirst;
    r.plast    = plast;
    r.seq      = seq_ctr;
    r.stamp    = rtp_clock;
    r.run_last = 1'b0;
    return r;
  endfunction

  // works out the payload bytes that one accepted nal byte gives, and queues them
  function automatic void packetize_byte(input logic [7:0] data,
                                         input logic [LENGTH_BITS-1:0] len,
                                         input logic opens);
    rtp_byte_t   burst[$];
    logic [15:0] room;
    logic        ends;
    logic [7:0]  fu_hdr;
    if (opens) begin
      // a new unit abandons the open one; a begun packet still uses up its number
      if (remain != 0 && pkt_fill != 0) seq_ctr++;
      remain    = '0;
      pkt_fill  = '0;
      drop_hdr  = 1'b0;
      s_pending = 1'b0;
      if (len == 0) return;
      cur_type   = data[6:1];
      // limit is latched per unit and never taken below the minimum
      unit_limit = (cfg_max_pkt < MIN_PACKET) ? MIN_PACKET : cfg_max_pkt;
      if (len <= unit_limit) begin
        frag_mode = 1'b0;
        remain    = len;
      end else begin
        // first nal header byte is dropped here, the second on the next byte
        frag_mode = 1'b1;
        remain    = len - 1'b1;
        drop_hdr  = 1'b1;
        s_pending = 1'b1;
        return;
      end
    end else if (remain == 0) begin
      return;
    end

    if (!frag_mode) begin
      ends = (remain == 1);
      burst.push_back(payload_of(data, pkt_fill == 0, ends));
      pkt_fill++;
      remain--;
      if (ends) begin
        seq_ctr++;
        pkt_fill = '0;
        // lone parameter sets share the timestamp of the picture that follows
        if (cur_type < TYPE_VPS || cur_type > TYPE_PPS) rtp_clock += cfg_ts_step;
      end
    end else if (drop_hdr) begin
      drop_hdr = 1'b0;
      remain--;
      return;
    end else begin
      room = unit_limit - FU_OVERHEAD;
      if (pkt_fill == 0) begin
        fu_hdr = {2'b00, cur_type};
        if (s_pending) fu_hdr |= S_BIT;
        if (remain <= room) fu_hdr |= E_BIT;
        s_pending = 1'b0;
        burst.push_back(payload_of(FU_INDICATOR, 1'b1, 1'b0));
        burst.push_back(payload_of(FU_LAYER_TID, 1'b0, 1'b0));
        burst.push_back(payload_of(fu_hdr, 1'b0, 1'b0));
      end
      pkt_fill++;
      remain--;
      ends = (pkt_fill >= room) || (remain == 0);
      burst.push_back(payload_of(data, 1'b0, ends));
      if (ends) begin
        seq_ctr++;
        pkt_fill = '0;
      end
      if (remain == 0) rtp_clock += cfg_ts_step;
    end

    if (burst.size() != 0) burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[i]) payload_exp.push_back(burst[i]);
  endfunction

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // compares one accepted payload byte with the oldest one still owed
  function automatic void check_payload();
    rtp_byte_t want;
    if (payload_exp.size() == 0) begin
      $display("%0t: payload byte %0h with none expected", $time, out_ch.payload_byte);
      errors++;
      return;
    end
    want = payload_exp.pop_front();
    field_check("payload_byte", 32'(want.data), 32'(out_ch.payload_byte));
    field_check("packet_first", 32'(want.pfirst), 32'(out_ch.packet_first));
    field_check("packet_last", 32'(want.plast), 32'(out_ch.packet_last));
    field_check("seq_number", 32'(want.seq), 32'(out_ch.seq_number));
    field_check("timestamp", want.stamp, out_ch.timestamp);
    field_check("run_last", 32'(want.run_last), 32'(out_ch.run_last));
  endfunction

  // monitor: register writes, input requests, output requests and the watchdog
  always @(posedge clk) begin
    if (rst) begin
      shadow_reset();
      idle_cycles <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_MAX_PACKET: cfg_max_pkt = pwdata[15:0];
          ADDR_TS_STEP:    cfg_ts_step = pwdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        packetize_byte(in_ch.nal_byte, in_ch.nal_length, in_ch.first_of_nal);
      if (out_ch.valid && out_ch.ready) check_payload();
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: back-pressure in random stalls while rx_stalls is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      rx_ready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      rx_ready   <= 1'b0;
      stall_left <= gap_len();
    end else begin
      rx_ready <= 1'b1;
    end
  end

  // one nal byte request; valid stays high afterwards so back-to-back bytes need no gap
  task automatic send_byte(input logic [7:0] data, input logic [LENGTH_BITS-1:0] len,
                           input logic opens);
    int unsigned gap;
    gap = tx_idle ? gap_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.nal_byte     <= data;
    in_ch.nal_length   <= len;
    in_ch.first_of_nal <= opens;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // first nsend bytes of a unit, from its header byte; later bytes carry junk lengths
  task automatic send_unit(input logic [7:0] hdr, input int unsigned len,
                           input int unsigned nsend);
    int unsigned i;
    for (i = 0; i < nsend; i++) begin
      if (i == 0) send_byte(hdr, LENGTH_BITS'(len), 1'b1);
      else send_byte(8'($urandom), LENGTH_BITS'($urandom), 1'b0);
    end
  endtask

  // stop sending and let every owed payload byte come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (payload_exp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_BITS-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_expect(input logic [PADDR_BITS-1:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0h read, expected %0h, got %0h", $time, addr, want, prdata);
      reg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // reset values, then both registers at their top values
  task automatic test_register_access();
    reg_expect(ADDR_MAX_PACKET, 32'(MAX_PACKET_RESET));
    reg_expect(ADDR_TS_STEP, TS_STEP_RESET);
    reg_write(ADDR_MAX_PACKET, 32'h0000_ffff);
    reg_write(ADDR_TS_STEP, 32'hffff_ffff);
    reg_expect(ADDR_MAX_PACKET, 32'h0000_ffff);
    reg_expect(ADDR_TS_STEP, 32'hffff_ffff);
  endtask

  // single-packet units, parameter sets that hold the timestamp, ignored bytes
  task automatic test_short_units();
    reg_write(ADDR_MAX_PACKET, 32'(MAX_PACKET_RESET));
    reg_write(ADDR_TS_STEP, TS_STEP_RESET);
    send_unit(8'hff, 1, 1);
    send_unit(HDR_VPS, 2, 2);
    send_unit(HDR_PPS, 2, 2);
    // stray byte with no unit open, then a first byte of zero length
    send_byte(8'h5a, '1, 1'b0);
    send_byte(8'ha5, '0, 1'b1);
    send_unit(8'h00, 1, 1);
    wait_idle();
  endtask

  // a limit below the minimum acts as the minimum: one data byte per fu packet
  task automatic test_tiny_limit();
    reg_write(ADDR_MAX_PACKET, 32'd1);
    reg_write(ADDR_TS_STEP, 32'hffff_ffff);
    send_byte(8'h02, LENGTH_BITS'(6), 1'b1);
    send_byte(8'h01, '0, 1'b0);
    send_byte(8'h00, '0, 1'b0);
    send_byte(8'hff, '1, 1'b0);
    send_byte(8'haa, '0, 1'b0);
    send_byte(8'h55, '0, 1'b0);
    wait_idle();
  endtask

  // limit rewritten inside an open unit, then units cut off by new ones
  task automatic test_abandoned_unit();
    reg_write(ADDR_MAX_PACKET, 32'd16);
    reg_write(ADDR_TS_STEP, 32'd1);
    send_unit(8'h26, 20, 5);
    // sender holds off until the open packet has drained, then the limit moves
    wait_idle();
    reg_write(ADDR_MAX_PACKET, 32'h0000_ffff);
    send_byte(8'h11, '0, 1'b0);
    send_byte(8'h22, '0, 1'b0);
    // new unit while a packet is half full; widest length, itself cut short
    send_unit(8'h7e, (1 << LENGTH_BITS) - 1, 3);
    send_unit(8'h01, 1, 1);
    wait_idle();
  endtask

  // mostly whole units with random content, some noise and cut-off units
  task automatic send_random_unit(inout int unsigned counted);
    int unsigned pick;
    int unsigned len;
    int unsigned nsend;
    logic [7:0]  hdr;
    pick = $urandom_range(0, 99);
    hdr  = 8'($urandom);
    if ($urandom_range(0, 3) == 0) hdr[6:1] = TYPE_VPS + 6'($urandom_range(0, 2));
    if (pick < 5) begin
      // stray byte, or a continuation of a unit cut off earlier
      send_byte(hdr, LENGTH_BITS'($urandom), 1'b0);
      if (open_unit) counted++;
      return;
    end
    if (pick < 10) begin
      send_byte(hdr, '0, 1'b1);
      open_unit = 1'b0;
      return;
    end
    if (pick < 22) begin
      len   = $urandom_range(1, (1 << LENGTH_BITS) - 1);
      nsend = $urandom_range(1, 4);
      if (nsend > len) nsend = len;
    end else if (phase_limit < 100 && $urandom_range(0, 1) == 1) begin
      len   = $urandom_range(phase_limit + 1, 3 * phase_limit);
      nsend = len;
    end else begin
      len   = $urandom_range(1, (phase_limit < 24) ? phase_limit : 24);
      nsend = len;
    end
    send_unit(hdr, len, nsend);
    open_unit = (nsend < len);
    counted += nsend;
  endtask

  // several register settings, extremes among them, with different idling on each side
  task automatic test_random_units();
    int unsigned phase;
    int unsigned counted;
    logic [31:0] step;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          phase_limit = 16;
          step        = 32'hffff_ffff;
          tx_idle     = 1'b1;
          rx_stalls   = 1'b1;
        end
        1: begin
          phase_limit = $urandom_range(16, 48);
          step        = $urandom;
          tx_idle     = 1'b0;
          rx_stalls   = 1'b0;
        end
        2: begin
          phase_limit = 65535;
          step        = '0;
          tx_idle     = 1'b1;
          rx_stalls   = 1'b0;
        end
        default: begin
          phase_limit = $urandom_range(16, 64);
          step        = TS_STEP_RESET;
          tx_idle     = 1'b0;
          rx_stalls   = 1'b1;
        end
      endcase
      reg_write(ADDR_MAX_PACKET, phase_limit);
      reg_write(ADDR_TS_STEP, step);
      counted   = 0;
      open_unit = 1'b0;
      while (counted < RANDOM_ITEMS / PHASES) send_random_unit(counted);
      wait_idle();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.nal_byte     <= '0;
    in_ch.nal_length   <= '0;
    in_ch.first_of_nal <= 1'b0;
    tx_idle            = 1'b1;
    rx_stalls          = 1'b1;
    reg_errors         = 0;
    phase_limit        = 16;
    open_unit          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_short_units();
    test_tiny_limit();
    test_abandoned_unit();
    test_random_units();
    wait_idle();

    if (errors == 0 && reg_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hfp_pkg.sv
rtl/hfp_channels.sv
rtl/hfp_front.sv
rtl/hfp_queue.sv
rtl/hfp_back.sv
rtl/hevc_rtp_fu_packetizer.sv
test/testbench.sv
